// ===== sv/table_driven_dfa_acceptor_unit_assert.svh =====
// Assertion macros shared by the automaton acceptor RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TABLE_DRIVEN_DFA_ACCEPTOR_UNIT_ASSERT_SVH
`define TABLE_DRIVEN_DFA_ACCEPTOR_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DFA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dfa_pkg.sv =====
// Types and codes for the table-driven automaton acceptor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dfa_pkg;

    localparam int STORE_SLOTS = 64;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_FEED = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    localparam logic [1:0] CFG_START_STATE = 2'd0;
    localparam logic [1:0] CFG_FINAL_MASK  = 2'd1;
    localparam logic [1:0] CFG_RULE_COUNT  = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] rule_index;
        logic [3:0] from_state;
        logic [7:0] symbol;
        logic [3:0] to_state;
    } in_word_t;

    typedef struct packed {
        logic       accepted;
        logic       blocked;
        logic [3:0] end_state;
    } out_word_t;

    typedef struct packed {
        logic [3:0] from_state;
        logic [7:0] symbol;
        logic [3:0] to_state;
    } rule_t;

    // commands from the top level to the scan sequencer
    typedef struct packed {
        logic       feed;
        logic       restart;
        logic [3:0] start;
        logic [7:0] symbol;
    } seq_cmd_t;

    typedef struct packed {
        logic       busy;
        logic       stuck;
        logic [3:0] cur_state;
    } seq_stat_t;

endpackage

// ===== sv/dfa_rule_mem.sv =====
// Rule store: one write port, one read port with registered read data.
// Depends on dfa_pkg for rule_t.
`timescale 1ns / 1ps

module dfa_rule_mem #(
    parameter int DEPTH = 64,
    parameter int ADDR_W = 6
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  dfa_pkg::rule_t      wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output dfa_pkg::rule_t      rd_data
);
    import dfa_pkg::*;

    rule_t mem [0:DEPTH-1];
    rule_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/dfa_seq.sv =====
// Scan sequencer: walks the rule store one slot per cycle with a single
// comparator, holds the current state and the blocked flag. Uses dfa_pkg.
`timescale 1ns / 1ps

`include "table_driven_dfa_acceptor_unit_assert.svh"

module dfa_seq #(
    parameter int DEPTH = 64,
    parameter int ADDR_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dfa_pkg::seq_cmd_t   cmd,
    input  logic [6:0]          rule_count,
    input  dfa_pkg::rule_t      rule,
    output logic                rd_en,
    output logic [ADDR_W-1:0]   rd_addr,
    output dfa_pkg::seq_stat_t  stat
);
    import dfa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } seq_state_t;

    seq_state_t fsm_reg, fsm_next;
    logic [3:0]       cur_reg, cur_next;
    logic             stuck_reg, stuck_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic [CNT_W-1:0] chk_reg, chk_next;
    logic             dvld_reg, dvld_next;
    logic [7:0]       sym_reg, sym_next;
    logic [CNT_W-1:0] limit;
    logic             hit;
    logic             last;

    // slots searched: rule_count clipped to the store depth
    assign limit = (rule_count >= 7'(DEPTH)) ? CNT_W'(DEPTH) : rule_count[CNT_W-1:0];

    assign rd_en   = (fsm_reg == S_SCAN) && (issue_reg < limit);
    assign rd_addr = issue_reg[ADDR_W-1:0];

    assign hit  = dvld_reg && (rule.from_state == cur_reg) && (rule.symbol == sym_reg);
    assign last = dvld_reg && (CNT_W'(chk_reg + 1'b1) == limit);

    always_comb
    begin
        fsm_next   = fsm_reg;
        cur_next   = cur_reg;
        stuck_next = stuck_reg;
        issue_next = issue_reg;
        chk_next   = chk_reg;
        dvld_next  = 1'b0;
        sym_next   = sym_reg;
        case (fsm_reg)
            S_IDLE:
            begin
                if (cmd.restart)
                begin
                    cur_next   = cmd.start;
                    stuck_next = 1'b0;
                end
                else if (cmd.feed && !stuck_reg)
                begin
                    if (limit == '0)
                    begin
                        stuck_next = 1'b1;
                    end
                    else
                    begin
                        fsm_next   = S_SCAN;
                        issue_next = '0;
                        chk_next   = '0;
                        sym_next   = cmd.symbol;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = CNT_W'(issue_reg + 1'b1);
                end
                if (dvld_reg)
                begin
                    chk_next = CNT_W'(chk_reg + 1'b1);
                end
                if (hit)
                begin
                    cur_next = rule.to_state;
                    fsm_next = S_IDLE;
                end
                else if (last)
                begin
                    stuck_next = 1'b1;
                    fsm_next   = S_IDLE;
                end
                else
                begin
                    dvld_next = rd_en;
                end
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg   <= S_IDLE;
            cur_reg   <= '0;
            stuck_reg <= 1'b0;
            issue_reg <= '0;
            chk_reg   <= '0;
            dvld_reg  <= 1'b0;
        end
        else
        begin
            fsm_reg   <= fsm_next;
            cur_reg   <= cur_next;
            stuck_reg <= stuck_next;
            issue_reg <= issue_next;
            chk_reg   <= chk_next;
            dvld_reg  <= dvld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
    end

    assign stat.busy      = (fsm_reg == S_SCAN);
    assign stat.stuck     = stuck_reg;
    assign stat.cur_state = cur_reg;

    `DFA_ASSERT_IMPL(a_chk_in_range, fsm_reg == S_SCAN, chk_reg < limit, "scan checked past limit")
    `DFA_ASSERT_IMPL(a_chk_behind_issue, fsm_reg == S_SCAN, chk_reg <= issue_reg, "check ahead of read")
    `DFA_ASSERT_IMPL(a_dvld_in_scan, dvld_reg, fsm_reg == S_SCAN, "read data pending while idle")

endmodule

// ===== sv/table_driven_dfa_acceptor_unit.sv =====
// Load: rule written to the store when accepted. Feed: up to 64 slots read in order until one
// matches, else the word is blocked; with no rule searched or on a blocked word, no scan runs.
// Throughput: a load or end word per cycle while idle and the output slot is free; a feed
// holds the input until its scan ends. End of word: result registered, valid the next cycle.
// Reset (rst_n, async, active low): control regs zero, idle; output data, rules not cleared.
`timescale 1ns / 1ps

`include "table_driven_dfa_acceptor_unit_assert.svh"

module table_driven_dfa_acceptor_unit #(
    parameter int STATE_COUNT = 16,
    parameter int RULE_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dfa_pkg::in_word_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dfa_pkg::out_word_t   out_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import dfa_pkg::*;

    localparam int MEM_DEPTH = (RULE_DEPTH < STORE_SLOTS) ? RULE_DEPTH : STORE_SLOTS;
    localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W = $clog2(MEM_DEPTH + 1);

    logic [3:0]  start_state_reg;
    logic [15:0] final_mask_reg;
    logic [6:0]  rule_count_reg;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_data_reg, out_data_next;

    logic        in_acc;
    logic        wr_en;
    logic        rd_en;
    logic [ADDR_W-1:0] rd_addr;
    rule_t       wr_rule;
    rule_t       rd_rule;
    seq_cmd_t    cmd;
    seq_stat_t   stat;
    logic        end_go;
    logic        in_range;

    assign in_ready = !stat.busy && (!out_valid_reg || out_ready);
    assign in_acc   = in_valid && in_ready;
    assign end_go   = in_acc && (in_data.operation == OP_END);

    assign wr_en = in_acc && (in_data.operation == OP_LOAD)
                   && ({1'b0, in_data.rule_index} < 7'(MEM_DEPTH));
    assign wr_rule.from_state = in_data.from_state;
    assign wr_rule.symbol     = in_data.symbol;
    assign wr_rule.to_state   = in_data.to_state;

    always_comb
    begin
        cmd.feed   = in_acc && (in_data.operation == OP_FEED);
        cmd.symbol = in_data.symbol;
        if (cfg_we && (cfg_index == CFG_START_STATE))
        begin
            cmd.restart = 1'b1;
            cmd.start   = cfg_data[3:0];
        end
        else
        begin
            cmd.restart = end_go;
            cmd.start   = start_state_reg;
        end
    end

    // states at or above STATE_COUNT never accept
    assign in_range = int'(stat.cur_state) < STATE_COUNT;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (end_go)
        begin
            out_valid_next          = 1'b1;
            out_data_next.accepted  = !stat.stuck && in_range
                                      && final_mask_reg[stat.cur_state];
            out_data_next.blocked   = stat.stuck;
            out_data_next.end_state = stat.cur_state;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
            final_mask_reg  <= '0;
            rule_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_STATE: start_state_reg <= cfg_data[3:0];
                    CFG_FINAL_MASK:  final_mask_reg  <= cfg_data;
                    CFG_RULE_COUNT:  rule_count_reg  <= cfg_data[6:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    dfa_rule_mem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (in_data.rule_index[ADDR_W-1:0]),
        .wr_data (wr_rule),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_rule)
    );

    dfa_seq #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rule_count (rule_count_reg),
        .rule       (rd_rule),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .stat       (stat)
    );

    `DFA_ASSERT_NEXT(a_end_gives_word, end_go, out_valid, "end of word gave no result")
    `DFA_ASSERT_IMPL(a_busy_not_ready, stat.busy, !in_ready, "input taken during scan")
    `DFA_ASSERT_IMPL(a_accept_unblocked, out_valid && out_data.accepted, !out_data.blocked, "blocked word accepted")

endmodule
